/* design/mse_pkg.sv */
`default_nettype none

package mse_pkg;

    localparam int MAX_ITEMS = 64;
    localparam int DATA_W    = 32;
    localparam int ADDR_W    = $clog2(MAX_ITEMS);
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;        // store (or drop) the accepted input beat
        logic sort_init;   // width to one, first run at zero, source buffer A
        logic run_init;    // set up pointers for the run pair at lo
        logic run_next;    // next run pair starts where this one ended
        logic merge_step;  // move one element into the destination buffer
        logic pass_next;   // double the run width, swap buffers
        logic sort_end;    // swap buffers so the sorted data is the source
        logic out_init;    // rewind the read pointer for output
        logic out_run;     // stream the source buffer to the output register
        logic batch_clear; // empty the buffer for the next batch
    } mse_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic             single;
        logic             run_done;
        logic             pass_done;
        logic             sort_done;
        logic             out_done;
        logic [CNT_W-1:0] count;
    } mse_sts_t;

endpackage

`default_nettype wire

/* design/merge_sort_engine_core.sv */
// Batch sorter for signed 32-bit values.
// Input stream: one value per beat on s_axis; tlast closes the batch. Up to
// MAX_ITEMS values are kept; further ones are dropped and the batch's results
// carry tuser (overflow) high. A tlast beat starts the sort even when dropped.
// While loading, the block takes each valid beat. After tlast it stops taking input
// and runs a bottom-up stable merge between two buffers: each pass moves every
// element once, with one set-up step per run pair, over ceil(log2(n)) passes, all
// bounded by the single destination write port.
// Output stream: sorted values ascending on m_axis, one beat per cycle while
// the receiver is ready, tlast on the final one. The results leave through an
// output register; while the receiver stalls, the register holds its beat and
// the read pointer waits. After the last result has moved into the output
// register, the controller clears the batch and returns to its load state,
// where input is taken again. Reset empties the buffer and the output
// register; no memory clearing is needed.
`default_nettype none

module merge_sort_engine_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [mse_pkg::DATA_W-1:0]        s_axis_tdata,   // [31:0] value
    input  logic                              s_axis_tlast,   // is_last
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [mse_pkg::DATA_W-1:0]        m_axis_tdata,   // [31:0] sorted_value
    output logic                              m_axis_tlast,   // last_out
    output logic [0:0]                        m_axis_tuser    // [0] overflow
);
    import mse_pkg::*;

    mse_cmd_t                 cmd;
    mse_sts_t                 sts;
    logic signed [DATA_W-1:0] out_data;
    logic                     out_overflow;

    mse_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_last  (s_axis_tlast),
        .sts      (sts),
        .in_ready (s_axis_tready),
        .cmd      (cmd)
    );

    mse_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .value        ($signed(s_axis_tdata)),
        .out_ready    (m_axis_tready),
        .sts          (sts),
        .out_valid    (m_axis_tvalid),
        .out_data     (out_data),
        .out_last     (m_axis_tlast),
        .out_overflow (out_overflow)
    );

    assign m_axis_tdata    = out_data;
    assign m_axis_tuser[0] = out_overflow;

    // The buffer never holds more than its capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sts.count <= CNT_W'(MAX_ITEMS))
        else $error("element count above capacity");

    // A closing beat stops the input side for the sort
    a_last_stops_input: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
        else $error("input taken right after the closing beat");

    // No input is taken while merging
    a_no_load_in_merge: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.merge_step |-> !s_axis_tready)
        else $error("input ready during merge");

endmodule

`default_nettype wire

/* design/mse_ctrl.sv */
`default_nettype none

module mse_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_last,
    input  mse_pkg::mse_sts_t sts,
    output logic              in_ready,
    output mse_pkg::mse_cmd_t cmd
);
    import mse_pkg::*;

    typedef enum logic [2:0] {
        S_LOAD,
        S_START,
        S_RUN,
        S_MERGE,
        S_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_LOAD:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (in_last)
                    begin
                        state_next = S_START;
                    end
                end
            end
            S_START:
            begin
                cmd.sort_init = 1'b1;
                if (sts.single)
                begin
                    cmd.out_init = 1'b1;
                    state_next   = S_OUT;
                end
                else
                begin
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                cmd.run_init = 1'b1;
                state_next   = S_MERGE;
            end
            S_MERGE:
            begin
                cmd.merge_step = 1'b1;
                if (sts.run_done)
                begin
                    if (!sts.pass_done)
                    begin
                        cmd.run_next = 1'b1;
                        state_next   = S_RUN;
                    end
                    else if (sts.sort_done)
                    begin
                        cmd.sort_end = 1'b1;
                        cmd.out_init = 1'b1;
                        state_next   = S_OUT;
                    end
                    else
                    begin
                        cmd.pass_next = 1'b1;
                        state_next    = S_RUN;
                    end
                end
            end
            S_OUT:
            begin
                cmd.out_run = 1'b1;
                if (sts.out_done)
                begin
                    cmd.batch_clear = 1'b1;
                    state_next      = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

/* design/mse_dp.sv */
`default_nettype none

module mse_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  mse_pkg::mse_cmd_t                   cmd,
    input  logic signed [mse_pkg::DATA_W-1:0]   value,
    input  logic                                out_ready,
    output mse_pkg::mse_sts_t                   sts,
    output logic                                out_valid,
    output logic signed [mse_pkg::DATA_W-1:0]   out_data,
    output logic                                out_last,
    output logic                                out_overflow
);
    import mse_pkg::*;

    localparam int SUM_W = CNT_W + 2;

    logic signed [DATA_W-1:0] mem_a [MAX_ITEMS];
    logic signed [DATA_W-1:0] mem_b [MAX_ITEMS];

    logic [CNT_W-1:0] count_reg, count_next;
    logic             dropped_reg, dropped_next;
    logic [CNT_W-1:0] width_reg, width_next;
    logic [CNT_W-1:0] lo_reg, lo_next;
    logic [CNT_W-1:0] mid_reg, mid_next;
    logic [CNT_W-1:0] hi_reg, hi_next;
    logic [CNT_W-1:0] l_reg, l_next;
    logic [CNT_W-1:0] r_reg, r_next;
    logic [CNT_W-1:0] o_reg, o_next;
    logic             src_reg, src_next;

    logic signed [DATA_W-1:0] rd_l_reg;
    logic signed [DATA_W-1:0] rd_r_reg;

    logic                     ov_reg, ov_next;
    logic signed [DATA_W-1:0] od_reg, od_next;
    logic                     olast_reg, olast_next;
    logic                     oovf_reg, oovf_next;

    logic [SUM_W-1:0]         n_ext, w2, mid_sum, hi_sum;
    logic [CNT_W-1:0]         mid_calc, hi_calc;
    logic                     full;
    logic                     take_left;
    logic signed [DATA_W-1:0] merge_data;
    logic                     out_load;

    logic                     wa_en, wb_en;
    logic [ADDR_W-1:0]        wa_addr;
    logic signed [DATA_W-1:0] wa_data;

    // Run bounds, clipped to the batch size
    always_comb
    begin
        n_ext    = SUM_W'(count_reg);
        w2       = SUM_W'(width_reg) << 1;
        mid_sum  = SUM_W'(lo_reg) + SUM_W'(width_reg);
        hi_sum   = SUM_W'(lo_reg) + w2;
        mid_calc = (mid_sum > n_ext) ? count_reg : mid_sum[CNT_W-1:0];
        hi_calc  = (hi_sum > n_ext) ? count_reg : hi_sum[CNT_W-1:0];
    end

    // Ties go to the left run to keep the sort stable
    assign take_left  = (l_reg < mid_reg) && ((r_reg >= hi_reg) || (rd_l_reg <= rd_r_reg));
    assign merge_data = take_left ? rd_l_reg : rd_r_reg;
    assign full       = (count_reg == CNT_W'(MAX_ITEMS));
    assign out_load   = cmd.out_run && (l_reg < count_reg) && (!ov_reg || out_ready);

    always_comb
    begin
        count_next   = count_reg;
        dropped_next = dropped_reg;
        width_next   = width_reg;
        lo_next      = lo_reg;
        mid_next     = mid_reg;
        hi_next      = hi_reg;
        l_next       = l_reg;
        r_next       = r_reg;
        o_next       = o_reg;
        src_next     = src_reg;

        if (cmd.batch_clear)
        begin
            count_next   = '0;
            dropped_next = 1'b0;
        end
        else if (cmd.load)
        begin
            if (full)
            begin
                dropped_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + CNT_W'(1);
            end
        end

        if (cmd.sort_init)
        begin
            width_next = CNT_W'(1);
            lo_next    = '0;
            src_next   = 1'b0;
        end
        if (cmd.pass_next)
        begin
            width_next = width_reg << 1;
            lo_next    = '0;
        end
        if (cmd.run_next)
        begin
            lo_next = hi_reg;
        end
        if (cmd.pass_next || cmd.sort_end)
        begin
            src_next = ~src_reg;
        end

        if (cmd.run_init)
        begin
            mid_next = mid_calc;
            hi_next  = hi_calc;
            l_next   = lo_reg;
            r_next   = mid_calc;
            o_next   = lo_reg;
        end
        else if (cmd.merge_step)
        begin
            o_next = o_reg + CNT_W'(1);
            if (take_left)
            begin
                l_next = l_reg + CNT_W'(1);
            end
            else
            begin
                r_next = r_reg + CNT_W'(1);
            end
        end

        if (cmd.out_init)
        begin
            l_next = '0;
        end
        else if (out_load)
        begin
            l_next = l_reg + CNT_W'(1);
        end
    end

    // Output register: refill when empty or when the held beat leaves
    always_comb
    begin
        ov_next    = ov_reg;
        od_next    = od_reg;
        olast_next = olast_reg;
        oovf_next  = oovf_reg;
        if (out_load)
        begin
            ov_next    = 1'b1;
            od_next    = rd_l_reg;
            olast_next = ((l_reg + CNT_W'(1)) == count_reg);
            oovf_next  = dropped_reg;
        end
        else if (out_ready)
        begin
            ov_next = 1'b0;
        end
    end

    always_comb
    begin
        wa_en   = (cmd.load && !full) || (cmd.merge_step && src_reg);
        wb_en   = cmd.merge_step && !src_reg;
        wa_addr = cmd.load ? count_reg[ADDR_W-1:0] : o_reg[ADDR_W-1:0];
        wa_data = cmd.load ? value : merge_data;
    end

    always_ff @(posedge clk)
    begin
        if (wa_en)
        begin
            mem_a[wa_addr] <= wa_data;
        end
        if (wb_en)
        begin
            mem_b[o_reg[ADDR_W-1:0]] <= merge_data;
        end
        rd_l_reg <= src_next ? mem_b[l_next[ADDR_W-1:0]] : mem_a[l_next[ADDR_W-1:0]];
        rd_r_reg <= src_next ? mem_b[r_next[ADDR_W-1:0]] : mem_a[r_next[ADDR_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            dropped_reg <= 1'b0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
            ov_reg      <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        width_reg <= width_next;
        lo_reg    <= lo_next;
        mid_reg   <= mid_next;
        hi_reg    <= hi_next;
        l_reg     <= l_next;
        r_reg     <= r_next;
        o_reg     <= o_next;
        src_reg   <= src_next;
        od_reg    <= od_next;
        olast_reg <= olast_next;
        oovf_reg  <= oovf_next;
    end

    always_comb
    begin
        sts.single    = (count_reg == CNT_W'(1));
        sts.run_done  = ((o_reg + CNT_W'(1)) == hi_reg);
        sts.pass_done = (hi_reg == count_reg);
        sts.sort_done = (w2 >= n_ext);
        sts.out_done  = (l_reg == count_reg);
        sts.count     = count_reg;
    end

    assign out_valid    = ov_reg;
    assign out_data     = od_reg;
    assign out_last     = olast_reg;
    assign out_overflow = oovf_reg;

endmodule

`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

    import mse_pkg::*;

    typedef struct {
        logic signed [DATA_W-1:0] value;
        logic                     last;
        logic                     overflow;
    } sorted_beat_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [DATA_W-1:0] s_axis_tdata = '0;   // [31:0] value
    logic              s_axis_tlast = 1'b0; // is_last
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [DATA_W-1:0] m_axis_tdata;        // [31:0] sorted_value
    logic              m_axis_tlast;        // last_out
    logic [0:0]        m_axis_tuser;        // [0] overflow

    // predictor state: the batch being loaded and whether it lost values
    logic signed [DATA_W-1:0] loaded_values[$];
    bit                       batch_dropped;
    sorted_beat_t             sorted_beat_q[$];
    sorted_beat_t             due_beat;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int ready_hold = 0;
    int beats_sent = 0;
    int batches_sent = 0;
    int overflow_batches = 0;
    int results_checked = 0;
    int fail_count = 0;

    merge_sort_engine_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Stable ascending sort of the loaded batch; queue one expected beat per value.
    task automatic predict_sorted_batch();
        logic signed [DATA_W-1:0] ordered[$];
        logic signed [DATA_W-1:0] pick;
        sorted_beat_t             beat;
        int                       j;
        ordered = loaded_values;
        for (int i = 1; i < ordered.size(); i++)
        begin
            pick = ordered[i];
            j = i - 1;
            // strict compare keeps equal values in arrival order
            while (j >= 0 && ordered[j] > pick)
            begin
                ordered[j + 1] = ordered[j];
                j--;
            end
            ordered[j + 1] = pick;
        end
        foreach (ordered[k])
        begin
            beat.value    = ordered[k];
            beat.last     = (k == ordered.size() - 1);
            beat.overflow = batch_dropped;
            sorted_beat_q = {sorted_beat_q, beat};
        end
        if (batch_dropped)
            overflow_batches++;
        batches_sent++;
        loaded_values.delete();
        batch_dropped = 0;
    endtask

    task automatic send_beat(input logic [DATA_W-1:0] value, input bit last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = value;
        s_axis_tlast  = last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        beats_sent++;
        if (loaded_values.size() < MAX_ITEMS)
            loaded_values = {loaded_values, value};
        else
            batch_dropped = 1;
        if (last)
            predict_sorted_batch();
        @(negedge clk);
    endtask

    function automatic logic [DATA_W-1:0] pick_value(input bit narrow);
        logic [DATA_W-1:0] corner[7];
        corner = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
                   32'h0000_0001, 32'h8000_0001, 32'h7FFF_FFFE};
        // narrow batches draw from a handful of values to force ties
        if (narrow)
            return DATA_W'($signed($urandom_range(6)) - 3);
        case ($urandom_range(9))
            0, 1:    return corner[$urandom_range(6)];
            2, 3:    return DATA_W'($signed($urandom_range(2000)) - 1000);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_random_batch(input int size);
        bit narrow;
        narrow = ($urandom_range(3) == 0);
        for (int i = 0; i < size; i++)
            send_beat(pick_value(narrow), i == size - 1);
    endtask

    task automatic send_list(input logic [DATA_W-1:0] values[$]);
        foreach (values[i])
            send_beat(values[i], i == values.size() - 1);
    endtask

    task automatic test_corner_batches();
        send_list('{32'h8000_0000});
        send_list('{32'h7FFF_FFFF});
        send_list('{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
                    32'h0000_0001, 32'h5555_5555, 32'hAAAA_AAAA, 32'h8000_0000,
                    32'h7FFF_FFFF});
        send_list('{32'h0000_0005, 32'h0000_0005});
        send_list('{32'h0000_0003, 32'h0000_0002, 32'h0000_0001, 32'h0000_0000,
                    32'hFFFF_FFFF, 32'hFFFF_FFFE});
    endtask

    // A full batch, then one that spills past capacity with the closing beat dropped.
    task automatic test_capacity();
        send_random_batch(MAX_ITEMS);
        send_random_batch(MAX_ITEMS + 2);
    endtask

    // Hold the output side while two batches are offered so the input backs up.
    task automatic test_backpressure();
        @(posedge clk);
        ready_hold = 400;
        @(negedge clk);
        send_random_batch(24);
        send_random_batch(24);
    endtask

    task automatic test_random_batches(input int idle_pct, input int stall_pct,
                                       input int beats);
        int start_beats;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        start_beats    = beats_sent;
        while (beats_sent - start_beats < beats)
        begin
            case ($urandom_range(19))
                0:       send_random_batch($urandom_range(MAX_ITEMS + 4, MAX_ITEMS));
                1, 2, 3: send_random_batch($urandom_range(40, 13));
                default: send_random_batch($urandom_range(12, 1));
            endcase
        end
    endtask

    always @(negedge clk)
    begin
        if (ready_hold > 0)
        begin
            m_axis_tready <= 1'b0;
            ready_hold    <= ready_hold - 1;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (sorted_beat_q.size() == 0)
            begin
                $error("unexpected result beat: sorted_value %0d", $signed(m_axis_tdata));
                fail_count++;
            end
            else
            begin
                due_beat = sorted_beat_q.pop_front();
                results_checked++;
                if (m_axis_tdata !== due_beat.value)
                begin
                    $error("sorted_value: expected %0d, got %0d",
                           due_beat.value, $signed(m_axis_tdata));
                    fail_count++;
                end
                if (m_axis_tlast !== due_beat.last)
                begin
                    $error("last_out: expected %0b, got %0b", due_beat.last, m_axis_tlast);
                    fail_count++;
                end
                if (m_axis_tuser[0] !== due_beat.overflow)
                begin
                    $error("overflow: expected %0b, got %0b",
                           due_beat.overflow, m_axis_tuser[0]);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_corner_batches();
        test_capacity();
        test_backpressure();
        test_random_batches(0, 0, 65);
        test_random_batches(46, 0, 65);
        test_random_batches(0, 46, 65);
        test_random_batches(32, 32, 65);

        s_axis_tvalid = 1'b0;
        s_axis_tlast  = 1'b0;
        while (sorted_beat_q.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Sent %0d beats in %0d batches (%0d overran capacity) under four idle mixes",
                 beats_sent, batches_sent, overflow_batches);
        $display("and one long output hold; %0d sorted beats checked.", results_checked);
        if (fail_count == 0)
            $display("** merge_sort_engine_core: PASSED **");
        else
            $display("** merge_sort_engine_core: FAILED **");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Timed out with %0d sorted beats still due.", sorted_beat_q.size());
        $display("** merge_sort_engine_core: FAILED **");
        $finish;
    end

endmodule

/* merge_sort_engine_core.f */
design/mse_pkg.sv
design/mse_ctrl.sv
design/mse_dp.sv
design/merge_sort_engine_core.sv
tb/tb_top.sv
